[src/clsup_pkg.sv]
// Shared types and constants of the control link supervisor.
// Used by the front, queue, back, top level and checker; depends on nothing.
package clsup_pkg;

   localparam int REQ_TDATA_W = 176;
   localparam int RSP_TDATA_W = 176;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 17;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int LANES       = 3;

   localparam int STICK_LIMIT = 500;
   localparam int US_PER_MS   = 1000;
   localparam int LIMIT_W     = 26;

   // floor(x / 500) == (x * RECIP_500) >> RECIP_SHIFT, exact for x < 2**26
   localparam logic [26:0] RECIP_500   = 27'd68719477;
   localparam int          RECIP_SHIFT = 35;

   localparam logic [1:0] OP_SWARM_CTRL  = 2'd0;
   localparam logic [1:0] OP_LEGACY_CTRL = 2'd1;
   localparam logic [1:0] OP_COMMAND     = 2'd2;
   localparam logic [1:0] OP_POLL        = 2'd3;

   localparam logic [7:0] CMD_STOP   = 8'd1;
   localparam logic [7:0] CMD_DISARM = 8'd2;
   localparam logic [7:0] CMD_ARM    = 8'd3;

   localparam logic [7:0] ARM_CODE_ARM  = 8'd1;
   localparam logic [7:0] ARM_CODE_STOP = 8'd2;

   localparam logic [CSR_ADDR_W-1:0] CSR_NODE_ID   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_BCAST_ID  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_TIMEOUT   = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_ANGLE_MAX = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_YAW_MAX   = 3'd4;

   typedef enum logic [2:0] {
      KIND_CONTROL,
      KIND_STOP,
      KIND_DISARM,
      KIND_ARM,
      KIND_POLL
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic [15:0]        throttle;
      logic signed [9:0]  roll;
      logic signed [9:0]  pitch;
      logic signed [9:0]  yaw;
      logic               arm_flag;
      logic               stop_flag;
      logic [7:0]         mode;
      logic [31:0]        seq;
      logic [47:0]        now_us;
   } item_type;

   typedef struct packed {
      logic [LIMIT_W-1:0] limit_us;
      logic [14:0]        angle_max;
      logic [16:0]        yaw_max;
   } cfg_type;

   typedef struct packed {
      logic        connected;
      logic [15:0] throttle_out;
      logic [15:0] roll_cdeg;
      logic [15:0] pitch_cdeg;
      logic [17:0] yaw_rate_cdps;
      logic        armed_out;
      logic        estop_out;
      logic [7:0]  mode_out;
      logic [31:0] sequence_out;
      logic [31:0] rx_count;
      logic [31:0] gap_count;
   } rsp_type;

endpackage

[src/clsup_front.sv]
// Front end: configuration registers, target filtering and classification of requests.
// Depends on clsup_pkg; feeds clsup_queue.
module clsup_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [1:0]                             req_tuser,
   input  logic [clsup_pkg::REQ_TDATA_W-1:0]      req_tdata,
   input  logic                                   csr_we,
   input  logic [clsup_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  logic [clsup_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic                                   push_ready,
   output logic                                   push_valid,
   output clsup_pkg::item_type                    push_item,
   output clsup_pkg::cfg_type                     cfg
);

   logic [7:0]                      node_ff;
   logic [7:0]                      bcast_ff;
   logic [clsup_pkg::LIMIT_W-1:0]   limit_ff;
   logic [14:0]                     angle_ff;
   logic [16:0]                     yaw_max_ff;

   logic [7:0]  target;
   logic [7:0]  arm_code;
   logic [7:0]  cmd;
   logic        addressed;
   logic        keep;

   function automatic logic signed [9:0] clamp_stick(input logic signed [15:0] s);
      logic signed [15:0] lim;
      lim = 16'(clsup_pkg::STICK_LIMIT);
      if (s > lim) begin
         clamp_stick = 10'(lim);
      end else if (s < -lim) begin
         clamp_stick = 10'(-lim);
      end else begin
         clamp_stick = s[9:0];
      end
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         node_ff    <= 8'd1;
         bcast_ff   <= 8'd255;
         limit_ff   <= clsup_pkg::LIMIT_W'(500 * clsup_pkg::US_PER_MS);
         angle_ff   <= 15'd3000;
         yaw_max_ff <= 17'd20000;
      end else if (csr_we) begin
         case (csr_addr)
            clsup_pkg::CSR_NODE_ID:   node_ff    <= csr_wdata[7:0];
            clsup_pkg::CSR_BCAST_ID:  bcast_ff   <= csr_wdata[7:0];
            // keep the watchdog limit in microseconds
            clsup_pkg::CSR_TIMEOUT:   limit_ff   <= clsup_pkg::LIMIT_W'(csr_wdata[15:0]) *
                                                    clsup_pkg::LIMIT_W'(clsup_pkg::US_PER_MS);
            clsup_pkg::CSR_ANGLE_MAX: angle_ff   <= csr_wdata[14:0];
            clsup_pkg::CSR_YAW_MAX:   yaw_max_ff <= csr_wdata[16:0];
            default: ;
         endcase
      end
   end

   assign target   = req_tdata[7:0];
   assign arm_code = req_tdata[79:72];
   assign cmd      = req_tdata[127:120];
   assign addressed = (target == node_ff) || (target == bcast_ff);

   always_comb begin
      keep           = 1'b0;
      push_item.kind = clsup_pkg::KIND_POLL;
      case (req_tuser)
         clsup_pkg::OP_SWARM_CTRL: begin
            keep           = addressed;
            push_item.kind = clsup_pkg::KIND_CONTROL;
         end
         clsup_pkg::OP_LEGACY_CTRL: begin
            keep           = 1'b1;
            push_item.kind = clsup_pkg::KIND_CONTROL;
         end
         clsup_pkg::OP_COMMAND: begin
            case (cmd)
               clsup_pkg::CMD_STOP: begin
                  keep           = addressed;
                  push_item.kind = clsup_pkg::KIND_STOP;
               end
               clsup_pkg::CMD_DISARM: begin
                  keep           = addressed;
                  push_item.kind = clsup_pkg::KIND_DISARM;
               end
               clsup_pkg::CMD_ARM: begin
                  keep           = addressed;
                  push_item.kind = clsup_pkg::KIND_ARM;
               end
               default: keep = 1'b0;
            endcase
         end
         clsup_pkg::OP_POLL: begin
            keep           = 1'b1;
            push_item.kind = clsup_pkg::KIND_POLL;
         end
         default: keep = 1'b0;
      endcase
      push_item.throttle  = req_tdata[23:8];
      push_item.roll      = clamp_stick(req_tdata[39:24]);
      push_item.pitch     = clamp_stick(req_tdata[55:40]);
      push_item.yaw       = clamp_stick(req_tdata[71:56]);
      push_item.arm_flag  = (arm_code == clsup_pkg::ARM_CODE_ARM);
      push_item.stop_flag = (arm_code == clsup_pkg::ARM_CODE_STOP);
      push_item.mode      = req_tdata[87:80];
      push_item.seq       = req_tdata[119:88];
      push_item.now_us    = req_tdata[175:128];
   end

   // drop filtered transactions without touching the queue
   assign req_tready = push_ready;
   assign push_valid = req_tvalid && keep;

   assign cfg.limit_us  = limit_ff;
   assign cfg.angle_max = angle_ff;
   assign cfg.yaw_max   = yaw_max_ff;

endmodule

[src/clsup_queue.sv]
// Two-entry queue of classified items between front and back.
// Depends on clsup_pkg.
module clsup_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  clsup_pkg::item_type in_item,
   output logic                out_valid,
   input  logic                out_ready,
   output clsup_pkg::item_type out_item
);

   clsup_pkg::item_type             mem_ff [clsup_pkg::QUEUE_DEPTH];
   logic [clsup_pkg::QPTR_W-1:0]    wr_ff;
   logic [clsup_pkg::QPTR_W-1:0]    rd_ff;
   logic [clsup_pkg::QPTR_W:0]      cnt_ff;
   logic [clsup_pkg::QPTR_W:0]      cnt_in;
   logic                            push;
   logic                            pop;

   assign in_ready  = (cnt_ff != (clsup_pkg::QPTR_W + 1)'(clsup_pkg::QUEUE_DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_item  = mem_ff[rd_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= in_item;
      end
   end

endmodule

[src/clsup_back.sv]
// Back end: link state, counters, watchdog and the stick scaling pipeline.
// Depends on clsup_pkg; drains clsup_queue and drives the response register.
module clsup_back (
   input  logic                clock,
   input  logic                reset,
   input  clsup_pkg::cfg_type  cfg,
   input  logic                q_valid,
   output logic                q_ready,
   input  clsup_pkg::item_type q_item,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output clsup_pkg::rsp_type  rsp
);

   typedef struct packed {
      logic                                connected;
      logic [15:0]                         throttle;
      logic [clsup_pkg::LANES-1:0]         neg;
      logic [clsup_pkg::LANES-1:0][8:0]    mag;
      logic                                arm_flag;
      logic                                stop_flag;
      logic [7:0]                          mode;
      logic [31:0]                         seq;
      logic [31:0]                         recv;
      logic [31:0]                         lost;
   } snap_type;

   typedef struct packed {
      logic                                connected;
      logic [15:0]                         throttle;
      logic [clsup_pkg::LANES-1:0]         neg;
      logic [clsup_pkg::LANES-1:0][25:0]   prod;
      logic                                arm_flag;
      logic                                stop_flag;
      logic [7:0]                          mode;
      logic [31:0]                         seq;
      logic [31:0]                         recv;
      logic [31:0]                         lost;
   } prod_type;

   // link state
   logic [47:0]       last_ff,  last_in;
   logic [31:0]       seq_ff,   seq_in;
   logic [31:0]       recv_ff,  recv_in;
   logic [31:0]       lost_ff,  lost_in;
   logic              first_ff, first_in;
   logic [15:0]       thr_ff,   thr_in;
   logic signed [9:0] roll_ff,  roll_in;
   logic signed [9:0] pitch_ff, pitch_in;
   logic signed [9:0] yaw_ff,   yaw_in;
   logic              armf_ff,  armf_in;
   logic              stopf_ff, stopf_in;
   logic [7:0]        mode_ff,  mode_in;

   // pipeline
   logic               s1_v_ff;
   snap_type           s1_ff, s1_in;
   logic               s2_v_ff;
   prod_type           s2_ff, s2_in;
   logic               out_v_ff;
   clsup_pkg::rsp_type out_ff, out_in;

   logic               out_adv;
   logic               s2_adv;
   logic               s1_adv;
   logic               pop;
   logic               is_poll;
   logic [31:0]        expected;
   logic [48:0]        elapsed;
   logic               fail;

   logic signed [9:0]                   stick [clsup_pkg::LANES];
   logic [16:0]                         lane_max [clsup_pkg::LANES];
   logic [52:0]                         full [clsup_pkg::LANES];
   logic [16:0]                         quot [clsup_pkg::LANES];
   logic [clsup_pkg::LANES-1:0][17:0]   sq;

   assign out_adv = !out_v_ff || rsp_ready;
   assign s2_adv  = !s2_v_ff || out_adv;
   assign s1_adv  = !s1_v_ff || s2_adv;

   assign is_poll = (q_item.kind == clsup_pkg::KIND_POLL);
   assign q_ready = !is_poll || s1_adv;
   assign pop     = q_valid && q_ready;

   assign expected = seq_ff + 32'd1;

   always_comb begin
      last_in  = last_ff;
      seq_in   = seq_ff;
      recv_in  = recv_ff;
      lost_in  = lost_ff;
      first_in = first_ff;
      thr_in   = thr_ff;
      roll_in  = roll_ff;
      pitch_in = pitch_ff;
      yaw_in   = yaw_ff;
      armf_in  = armf_ff;
      stopf_in = stopf_ff;
      mode_in  = mode_ff;
      if (pop) begin
         case (q_item.kind)
            clsup_pkg::KIND_CONTROL: begin
               if (!first_ff && (q_item.seq > expected)) begin
                  lost_in = lost_ff + (q_item.seq - expected);
               end
               first_in = 1'b0;
               seq_in   = q_item.seq;
               thr_in   = q_item.throttle;
               roll_in  = q_item.roll;
               pitch_in = q_item.pitch;
               yaw_in   = q_item.yaw;
               armf_in  = q_item.arm_flag;
               stopf_in = q_item.stop_flag;
               mode_in  = q_item.mode;
               last_in  = q_item.now_us;
               recv_in  = recv_ff + 32'd1;
            end
            clsup_pkg::KIND_STOP: begin
               armf_in  = 1'b0;
               stopf_in = 1'b1;
               thr_in   = '0;
               last_in  = q_item.now_us;
            end
            clsup_pkg::KIND_DISARM: begin
               armf_in  = 1'b0;
               stopf_in = 1'b0;
               thr_in   = '0;
               last_in  = q_item.now_us;
            end
            clsup_pkg::KIND_ARM: begin
               armf_in  = 1'b1;
               stopf_in = 1'b0;
               last_in  = q_item.now_us;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff  <= '0;
         seq_ff   <= '0;
         recv_ff  <= '0;
         lost_ff  <= '0;
         first_ff <= 1'b1;
         thr_ff   <= '0;
         roll_ff  <= '0;
         pitch_ff <= '0;
         yaw_ff   <= '0;
         armf_ff  <= 1'b0;
         stopf_ff <= 1'b0;
         mode_ff  <= '0;
      end else begin
         last_ff  <= last_in;
         seq_ff   <= seq_in;
         recv_ff  <= recv_in;
         lost_ff  <= lost_in;
         first_ff <= first_in;
         thr_ff   <= thr_in;
         roll_ff  <= roll_in;
         pitch_ff <= pitch_in;
         yaw_ff   <= yaw_in;
         armf_ff  <= armf_in;
         stopf_ff <= stopf_in;
         mode_ff  <= mode_in;
      end
   end

   // watchdog: a time stamp of zero reads as never, negative elapsed never trips
   assign elapsed = {1'b0, q_item.now_us} - {1'b0, last_ff};
   assign fail    = (last_ff == '0) ||
                    ($signed(elapsed) > $signed({23'd0, cfg.limit_us}));

   assign stick[0] = roll_ff;
   assign stick[1] = pitch_ff;
   assign stick[2] = yaw_ff;

   always_comb begin
      s1_in.connected = !fail;
      s1_in.throttle  = fail ? '0 : thr_ff;
      s1_in.arm_flag  = !fail && armf_ff;
      s1_in.stop_flag = !fail && stopf_ff;
      s1_in.mode      = fail ? '0 : mode_ff;
      s1_in.seq       = seq_ff;
      s1_in.recv      = recv_ff;
      s1_in.lost      = lost_ff;
      for (int i = 0; i < clsup_pkg::LANES; i++) begin
         s1_in.neg[i] = !fail && stick[i][9];
         if (fail) begin
            s1_in.mag[i] = '0;
         end else if (stick[i][9]) begin
            s1_in.mag[i] = 9'(10'd0 - stick[i]);
         end else begin
            s1_in.mag[i] = stick[i][8:0];
         end
      end
   end

   assign lane_max[0] = {2'b00, cfg.angle_max};
   assign lane_max[1] = {2'b00, cfg.angle_max};
   assign lane_max[2] = cfg.yaw_max;

   always_comb begin
      s2_in.connected = s1_ff.connected;
      s2_in.throttle  = s1_ff.throttle;
      s2_in.neg       = s1_ff.neg;
      s2_in.arm_flag  = s1_ff.arm_flag;
      s2_in.stop_flag = s1_ff.stop_flag;
      s2_in.mode      = s1_ff.mode;
      s2_in.seq       = s1_ff.seq;
      s2_in.recv      = s1_ff.recv;
      s2_in.lost      = s1_ff.lost;
      for (int i = 0; i < clsup_pkg::LANES; i++) begin
         s2_in.prod[i] = 26'(s1_ff.mag[i]) * 26'(lane_max[i]);
      end
   end

   // divide by the stick limit through the reciprocal, then restore the sign
   always_comb begin
      for (int i = 0; i < clsup_pkg::LANES; i++) begin
         full[i] = 53'(s2_ff.prod[i]) * 53'(clsup_pkg::RECIP_500);
         quot[i] = full[i][clsup_pkg::RECIP_SHIFT +: 17];
         sq[i]   = s2_ff.neg[i] ? (18'd0 - {1'b0, quot[i]}) : {1'b0, quot[i]};
      end
      out_in.connected     = s2_ff.connected;
      out_in.throttle_out  = s2_ff.throttle;
      out_in.roll_cdeg     = sq[0][15:0];
      out_in.pitch_cdeg    = sq[1][15:0];
      out_in.yaw_rate_cdps = sq[2];
      out_in.armed_out     = s2_ff.arm_flag;
      out_in.estop_out     = s2_ff.stop_flag;
      out_in.mode_out      = s2_ff.mode;
      out_in.sequence_out  = s2_ff.seq;
      out_in.rx_count      = s2_ff.recv;
      out_in.gap_count     = s2_ff.lost;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (s1_adv) begin
            s1_v_ff <= pop && is_poll;
         end
         if (s2_adv) begin
            s2_v_ff <= s1_v_ff;
         end
         if (out_adv) begin
            out_v_ff <= s2_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s1_ff <= s1_in;
      end
      if (s2_adv) begin
         s2_ff <= s2_in;
      end
      if (out_adv) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp       = out_ff;

endmodule

[src/control_link_supervisor_core.sv]
// Top level of the control link supervisor: front, queue and back end.
// Depends on clsup_pkg, clsup_front, clsup_queue and clsup_back.
//
//  channel | direction | handshake           | payload
//  req     | in        | req_tvalid/tready   | tuser: opcode; tdata: target..now_us
//  rsp     | out       | rsp_tvalid/tready   | tuser: connected; tdata: throttle_out..gap_count
//  csr     | in        | csr_we              | csr_addr register index, csr_wdata value
//
// One transaction per cycle on req when rsp is not backed up.
// A poll reaches rsp at the earliest after passing the queue, the watchdog
// snapshot, the product, then the reciprocal-multiply output register.
// Other transactions give no response; those kept by the target filter update state.
// Synchronous active-high reset clears state, the queue and the pipeline.
// A stalled rsp fills the pipeline and then the two-entry queue before req stalls.
module control_link_supervisor_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // opcode[1:0]
   input  logic [1:0]                        req_tuser,
   // target[7:0], throttle[23:8], roll[39:24], pitch[55:40], yaw[71:56],
   // arm[79:72], mode[87:80], sequence_req[119:88], command_id[127:120],
   // now_us[175:128]
   input  logic [clsup_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // connected
   output logic                              rsp_tuser,
   // throttle_out[15:0], roll_cdeg[31:16], pitch_cdeg[47:32],
   // yaw_rate_cdps[65:48], armed_out[66], estop_out[67], mode_out[75:68],
   // sequence_out[107:76], rx_count[139:108], gap_count[171:140],
   // zero[175:172]
   output logic [clsup_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                              csr_we,
   input  logic [clsup_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [clsup_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   clsup_pkg::cfg_type  cfg;
   logic                push_valid;
   logic                push_ready;
   clsup_pkg::item_type push_item;
   logic                q_valid;
   logic                q_ready;
   clsup_pkg::item_type q_item;
   clsup_pkg::rsp_type  rsp;

   clsup_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_item  (push_item),
      .cfg        (cfg)
   );

   clsup_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_item   (push_item),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_item  (q_item)
   );

   clsup_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_item    (q_item),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   assign rsp_tuser = rsp.connected;
   assign rsp_tdata = {4'd0,
                       rsp.gap_count,
                       rsp.rx_count,
                       rsp.sequence_out,
                       rsp.mode_out,
                       rsp.estop_out,
                       rsp.armed_out,
                       rsp.yaw_rate_cdps,
                       rsp.pitch_cdeg,
                       rsp.roll_cdeg,
                       rsp.throttle_out};

endmodule

[src/clsup_checker.sv]
// Port-level checks on the response channel of the control link supervisor.
// Depends on clsup_pkg; bound to control_link_supervisor_core at the end of the file.
module clsup_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic                              rsp_tuser,
   input logic [clsup_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   // reset empties the response pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // failsafe snapshot: throttle, sticks, flags and mode all zero
   a_failsafe_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[75:0] == '0)
      else $error("failsafe response carries live values");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[66] && rsp_tdata[67]))
      else $error("arm and emergency stop both set");

endmodule

bind control_link_supervisor_core clsup_checker u_clsup_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tdata  (rsp_tdata)
);
